/* rtl/rpz_pkg.sv */
// rpz_pkg: shared constants, register indexes and controller/datapath structs
// for the rssi proximity zone classifier; depends on nothing
package rpz_pkg;

    localparam int DEPTH_DEF  = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FAR_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE2_ENTRY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE3_ENTRY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE4_ENTRY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE5_ENTRY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 3'd7;

    localparam logic signed [7:0] FAR_RST   = -8'sd90;
    localparam logic signed [7:0] NEAR_RST  = -8'sd50;
    localparam logic signed [7:0] ZONE2_RST = -8'sd80;
    localparam logic signed [7:0] ZONE3_RST = -8'sd70;
    localparam logic signed [7:0] ZONE4_RST = -8'sd60;
    localparam logic signed [7:0] ZONE5_RST = -8'sd50;
    localparam logic [5:0]        HYST_RST  = 6'd3;
    localparam logic [15:0]       TMO_RST   = 16'd2000;

    localparam int IDLE_W = 17;

    localparam logic [2:0] ZONE_1 = 3'd1;
    localparam logic [2:0] ZONE_2 = 3'd2;
    localparam logic [2:0] ZONE_3 = 3'd3;
    localparam logic [2:0] ZONE_4 = 3'd4;
    localparam logic [2:0] ZONE_5 = 3'd5;

    localparam logic [7:0] BRT_MIN = 8'd0;
    localparam logic [7:0] BRT_MAX = 8'd255;

    localparam int DIV_N_W   = 16;
    localparam int DIV_D_W   = 9;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic in_ready;
        logic sample_upd;
        logic classify;
        logic tick_upd;
        logic brt_eval;
        logic brt_done;
        logic out_load;
    } rpz_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_tick;
        logic avg_done;
        logic div_done;
        logic brt_sat;
        logic out_free;
    } rpz_stat_t;

endpackage

/* rtl/rpz_if.sv */
// rpz_if: valid/ready channel interfaces for input words, result words and
// configuration writes; depends on rpz_pkg
interface rpz_item_if ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic signed [7:0] rssi_dbm;

    modport source (output valid, req_type, rssi_dbm, input ready);
    modport sink   (input valid, req_type, rssi_dbm, output ready);
endinterface

interface rpz_result_if ();
    logic              valid;
    logic              ready;
    logic signed [7:0] smoothed_dbm;
    logic [2:0]        zone;
    logic [7:0]        brightness;
    logic              signal_present;
    logic              signal_lost_event;
    logic              searching;

    modport source (output valid, smoothed_dbm, zone, brightness, signal_present,
                    signal_lost_event, searching, input ready);
    modport sink   (input valid, smoothed_dbm, zone, brightness, signal_present,
                    signal_lost_event, searching, output ready);
endinterface

interface rpz_cfg_if import rpz_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/rpz_ram.sv */
// rpz_ram: generic single write port ram with registered read
// depends on nothing
module rpz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rpz_div.sv */
// rpz_div: unsigned restoring divider, one quotient bit per cycle
// depends on rpz_pkg
module rpz_div import rpz_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   dvs_reg;

    logic [DIV_D_W:0]     rem_sh;
    logic [DIV_D_W:0]     rem_dif;
    logic                 fits;
    logic [DIV_D_W-1:0]   rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIV_N_W-1]};
        rem_dif  = rem_sh - {1'b0, dvs_reg};
        fits     = rem_sh >= {1'b0, dvs_reg};
        rem_next = fits ? rem_dif[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/rpz_datapath.sv */
// rpz_datapath: configuration registers, sample ring, running sum, zone
// hysteresis, brightness and output register; depends on rpz_pkg, rpz_if,
// rpz_ram and rpz_div
module rpz_datapath import rpz_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rpz_item_if.sink     item,
    rpz_result_if.source result,
    rpz_cfg_if.sink      cfg,
    input  rpz_cmd_t     cmd,
    output rpz_stat_t    stat
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int SUM_W  = PTR_W + 8;
    localparam int SEED_W = $clog2(DEPTH + 1);
    localparam int AVG_SH = SUM_W + PTR_W;
    localparam int AVG_MUL = ((1 << AVG_SH) + DEPTH - 1) / DEPTH;
    localparam logic [PTR_W-1:0]        PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [SEED_W-1:0]       SEED_FULL = SEED_W'(DEPTH);
    localparam logic signed [SUM_W-1:0] DEPTH_S   = SUM_W'(DEPTH);
    localparam logic signed [SUM_W-1:0] SUM_RST   = SUM_W'(int'(FAR_RST) * DEPTH);
    localparam logic [IDLE_W-1:0]       IDLE_MAX  = '1;
    localparam logic [AVG_SH-1:0]       AVG_MUL_C = AVG_SH'(AVG_MUL);

    // configuration registers
    logic signed [7:0] far_reg;
    logic signed [7:0] near_reg;
    logic signed [7:0] z2_reg;
    logic signed [7:0] z3_reg;
    logic signed [7:0] z4_reg;
    logic signed [7:0] z5_reg;
    logic [5:0]        hyst_reg;
    logic [15:0]       tmo_reg;

    // block state
    logic [PTR_W-1:0]        ptr_reg;
    logic [DEPTH-1:0]        valid_reg;
    logic signed [7:0]       fill_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    avg_busy_reg;
    logic                    avg_done_reg;
    logic signed [7:0]       avg_reg;
    logic [2:0]              zone_reg;
    logic [IDLE_W-1:0]       idle_reg;
    logic                    link_reg;
    logic [SEED_W-1:0]       seed_reg;
    logic signed [7:0]       last_reg;
    logic                    lost_reg;
    logic [7:0]              bright_reg;
    logic signed [7:0]       rssi_reg;

    // output word
    logic              out_valid_reg;
    logic signed [7:0] out_smoothed_reg;
    logic [2:0]        out_zone_reg;
    logic [7:0]        out_bright_reg;
    logic              out_present_reg;
    logic              out_lost_reg;
    logic              out_search_reg;

    logic                    accept;
    logic [7:0]              ram_rdata;
    logic signed [7:0]       old_val;
    logic signed [SUM_W-1:0] sum_upd;
    logic [SUM_W-1:0]        sum_mag;
    logic [PTR_W-1:0]        ptr_next;

    logic                    div_start;
    logic [DIV_N_W-1:0]      div_dvd;
    logic [DIV_D_W-1:0]      div_dvs;
    logic                    div_done;
    logic [DIV_N_W-1:0]      div_quo;

    logic [SUM_W+AVG_SH-1:0] avg_prod;
    logic [7:0]              avg_mag;
    logic signed [7:0]       avg;
    logic [2:0]              raw_zone;
    logic signed [7:0]       entry_cur;
    logic signed [9:0]       thr_down;
    logic [2:0]              zone_next;

    logic [IDLE_W-1:0]       idle_inc;
    logic                    lost_now;

    logic                    brt_lo;
    logic                    brt_hi;
    logic [8:0]              brt_diff;
    logic [16:0]             brt_prod;
    logic [DIV_D_W-1:0]      brt_den;

    assign accept     = cmd.in_ready & item.valid;
    assign item.ready = cmd.in_ready;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            far_reg  <= FAR_RST;
            near_reg <= NEAR_RST;
            z2_reg   <= ZONE2_RST;
            z3_reg   <= ZONE3_RST;
            z4_reg   <= ZONE4_RST;
            z5_reg   <= ZONE5_RST;
            hyst_reg <= HYST_RST;
            tmo_reg  <= TMO_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FAR_LEVEL:   far_reg  <= cfg.data[7:0];
                REG_NEAR_LEVEL:  near_reg <= cfg.data[7:0];
                REG_ZONE2_ENTRY: z2_reg   <= cfg.data[7:0];
                REG_ZONE3_ENTRY: z3_reg   <= cfg.data[7:0];
                REG_ZONE4_ENTRY: z4_reg   <= cfg.data[7:0];
                REG_ZONE5_ENTRY: z5_reg   <= cfg.data[7:0];
                REG_HYSTERESIS:  hyst_reg <= cfg.data[5:0];
                REG_TIMEOUT_MS:  tmo_reg  <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    rpz_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.sample_upd),
        .waddr (ptr_reg),
        .wdata (rssi_reg),
        .re    (accept),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // entries not written since reset or signal loss read as the fill level
    always_comb
    begin
        old_val  = valid_reg[ptr_reg] ? $signed(ram_rdata) : fill_reg;
        sum_upd  = sum_reg - SUM_W'(old_val) + SUM_W'(rssi_reg);
        ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
    end

    // average quotient back to signed, truncated toward zero
    always_comb
    begin
        sum_mag  = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
        avg_prod = (SUM_W+AVG_SH)'(sum_mag) * (SUM_W+AVG_SH)'(AVG_MUL_C);
        avg_mag  = avg_prod[AVG_SH +: 8];
        avg      = sum_reg[SUM_W-1] ? -$signed(avg_mag) : $signed(avg_mag);
    end

    always_comb
    begin
        if (avg_reg >= z5_reg)
        begin
            raw_zone = ZONE_5;
        end
        else if (avg_reg >= z4_reg)
        begin
            raw_zone = ZONE_4;
        end
        else if (avg_reg >= z3_reg)
        begin
            raw_zone = ZONE_3;
        end
        else if (avg_reg >= z2_reg)
        begin
            raw_zone = ZONE_2;
        end
        else
        begin
            raw_zone = ZONE_1;
        end

        unique case (zone_reg)
            ZONE_2:  entry_cur = z2_reg;
            ZONE_3:  entry_cur = z3_reg;
            ZONE_4:  entry_cur = z4_reg;
            ZONE_5:  entry_cur = z5_reg;
            default: entry_cur = 8'sd0;
        endcase

        thr_down = 10'(entry_cur) - $signed({4'b0000, hyst_reg});

        zone_next = zone_reg;
        if (raw_zone > zone_reg)
        begin
            zone_next = raw_zone;
        end
        else if (raw_zone < zone_reg && 10'(avg_reg) < thr_down)
        begin
            zone_next = raw_zone;
        end
    end

    always_comb
    begin
        idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 1'b1;
        lost_now = link_reg && (idle_inc > {1'b0, tmo_reg});
    end

    // brightness: (s - far) * 255 / (near - far) between the two levels
    always_comb
    begin
        brt_lo   = last_reg <= far_reg;
        brt_hi   = last_reg >= near_reg;
        brt_diff = {last_reg[7], last_reg} - {far_reg[7], far_reg};
        brt_prod = {brt_diff, 8'h00} - {8'h00, brt_diff};
        brt_den  = {near_reg[7], near_reg} - {far_reg[7], far_reg};
    end

    always_comb
    begin
        div_start = cmd.brt_eval & ~(brt_lo | brt_hi);
        div_dvd   = brt_prod[DIV_N_W-1:0];
        div_dvs   = brt_den;
    end

    rpz_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg      <= '0;
            valid_reg    <= '0;
            fill_reg     <= FAR_RST;
            sum_reg      <= SUM_RST;
            avg_busy_reg <= 1'b0;
            avg_done_reg <= 1'b0;
            zone_reg     <= ZONE_1;
            idle_reg     <= '0;
            link_reg     <= 1'b0;
            seed_reg     <= '0;
            last_reg     <= FAR_RST;
            lost_reg     <= 1'b0;
        end
        else
        begin
            avg_busy_reg <= cmd.sample_upd;
            avg_done_reg <= avg_busy_reg;
            if (cmd.sample_upd)
            begin
                sum_reg            <= sum_upd;
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg            <= ptr_next;
                idle_reg           <= '0;
                link_reg           <= 1'b1;
                lost_reg           <= 1'b0;
                if (seed_reg != SEED_FULL)
                begin
                    seed_reg <= seed_reg + 1'b1;
                end
            end
            if (cmd.classify)
            begin
                last_reg <= avg_reg;
                zone_reg <= zone_next;
            end
            if (cmd.tick_upd)
            begin
                idle_reg <= idle_inc;
                lost_reg <= lost_now;
                if (lost_now)
                begin
                    link_reg  <= 1'b0;
                    zone_reg  <= ZONE_1;
                    valid_reg <= '0;
                    fill_reg  <= far_reg;
                    sum_reg   <= SUM_W'(far_reg) * DEPTH_S;
                    last_reg  <= far_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rssi_reg <= item.rssi_dbm;
        end
        if (avg_busy_reg)
        begin
            avg_reg <= avg;
        end
        if (cmd.brt_eval)
        begin
            if (brt_lo)
            begin
                bright_reg <= BRT_MIN;
            end
            else if (brt_hi)
            begin
                bright_reg <= BRT_MAX;
            end
        end
        if (cmd.brt_done)
        begin
            bright_reg <= div_quo[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_smoothed_reg <= last_reg;
            out_zone_reg     <= zone_reg;
            out_bright_reg   <= bright_reg;
            out_present_reg  <= link_reg;
            out_lost_reg     <= lost_reg;
            out_search_reg   <= seed_reg != SEED_FULL;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.smoothed_dbm      = out_smoothed_reg;
    assign result.zone              = out_zone_reg;
    assign result.brightness        = out_bright_reg;
    assign result.signal_present    = out_present_reg;
    assign result.signal_lost_event = out_lost_reg;
    assign result.searching         = out_search_reg;

    assign stat.in_valid = item.valid;
    assign stat.in_tick  = item.req_type;
    assign stat.avg_done = avg_done_reg;
    assign stat.div_done = div_done;
    assign stat.brt_sat  = brt_lo | brt_hi;
    assign stat.out_free = ~out_valid_reg | result.ready;

endmodule

/* rtl/rpz_ctrl.sv */
// rpz_ctrl: sequencing state machine for one word at a time
// depends on rpz_pkg
module rpz_ctrl import rpz_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  rpz_stat_t stat,
    output rpz_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_UPD      = 3'd1;
    localparam logic [2:0] ST_TICK     = 3'd2;
    localparam logic [2:0] ST_WAIT_AVG = 3'd3;
    localparam logic [2:0] ST_BRT      = 3'd4;
    localparam logic [2:0] ST_WAIT_BRT = 3'd5;
    localparam logic [2:0] ST_OUT      = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    state_next = stat.in_tick ? ST_TICK : ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.sample_upd = 1'b1;
                state_next     = ST_WAIT_AVG;
            end
            ST_TICK:
            begin
                cmd.tick_upd = 1'b1;
                state_next   = ST_BRT;
            end
            ST_WAIT_AVG:
            begin
                if (stat.avg_done)
                begin
                    cmd.classify = 1'b1;
                    state_next   = ST_BRT;
                end
            end
            ST_BRT:
            begin
                cmd.brt_eval = 1'b1;
                state_next   = stat.brt_sat ? ST_OUT : ST_WAIT_BRT;
            end
            ST_WAIT_BRT:
            begin
                if (stat.div_done)
                begin
                    cmd.brt_done = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/rssi_proximity_zone_classifier_top.sv */
// rssi_proximity_zone_classifier_top: sample: ring update, average, classify,
// brightness, output; tick: timeout check, brightness, output; divide if needed
// throughput: one word in flight; the next is taken the cycle after the result
// is loaded; the 16-step brightness divider sets the worst case
// reset: async active low, config to defaults, ring reads as far level at once
// depends on rpz_pkg, rpz_if, rpz_ctrl and rpz_datapath
module rssi_proximity_zone_classifier_top import rpz_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rpz_item_if.sink     item,
    rpz_result_if.source result,
    rpz_cfg_if.sink      cfg
);

    rpz_cmd_t  cmd;
    rpz_stat_t stat;

    rpz_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    rpz_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg),
        .cmd    (cmd),
        .stat   (stat)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("word accepted while previous word in flight");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_loss_resets_zone: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.signal_lost_event |->
            !result.signal_present && result.zone == ZONE_1)
        else $error("signal loss without zone reset");

    a_zone_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.zone >= ZONE_1 && result.zone <= ZONE_5)
        else $error("zone out of range");

endmodule

/* sim/testbench.sv */
// testbench: drives sample and tick words plus config writes into the rssi proximity
// zone classifier, predicts every result word and checks it field by field
// depends on rpz_pkg, rpz_if and rssi_proximity_zone_classifier_top
`timescale 1ns / 1ps

import rpz_pkg::*;

localparam int   RING_DEPTH = DEPTH_DEF;
localparam int   QUIET_MAX  = (1 << IDLE_W) - 1;
localparam logic REQ_SAMPLE = 1'b0;
localparam logic REQ_TICK   = 1'b1;

typedef struct packed {
    logic signed [7:0] smoothed;
    logic [2:0]        zone;
    logic [7:0]        brightness;
    logic              present;
    logic              lost;
    logic              searching;
} zone_word_t;

class zone_scoreboard;
    int         far_lvl;
    int         near_lvl;
    int         entry_lvl [2:5];
    int         hyst;
    int         tmo;
    int         ring [RING_DEPTH];
    int         wr_ptr;
    int         ring_sum;
    logic [2:0] cur_zone;
    int         quiet_ms;
    bit         linked;
    int         seeds;
    int         avg_lvl;
    zone_word_t expected_q [$];
    int         errors;

    function new();
        far_lvl      = FAR_RST;
        near_lvl     = NEAR_RST;
        entry_lvl[2] = ZONE2_RST;
        entry_lvl[3] = ZONE3_RST;
        entry_lvl[4] = ZONE4_RST;
        entry_lvl[5] = ZONE5_RST;
        hyst         = HYST_RST;
        tmo          = TMO_RST;
        refill_ring();
        wr_ptr       = 0;
        cur_zone     = ZONE_1;
        quiet_ms     = 0;
        linked       = 1'b0;
        seeds        = 0;
        avg_lvl      = far_lvl;
        errors       = 0;
    endfunction

    function void refill_ring();
        foreach (ring[i])
            ring[i] = far_lvl;
        ring_sum = far_lvl * RING_DEPTH;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FAR_LEVEL:   far_lvl      = $signed(data[7:0]);
            REG_NEAR_LEVEL:  near_lvl     = $signed(data[7:0]);
            REG_ZONE2_ENTRY: entry_lvl[2] = $signed(data[7:0]);
            REG_ZONE3_ENTRY: entry_lvl[3] = $signed(data[7:0]);
            REG_ZONE4_ENTRY: entry_lvl[4] = $signed(data[7:0]);
            REG_ZONE5_ENTRY: entry_lvl[5] = $signed(data[7:0]);
            REG_HYSTERESIS:  hyst         = data[5:0];
            REG_TIMEOUT_MS:  tmo          = data;
            default:         ;
        endcase
    endfunction

    function void note_word(logic req, logic signed [7:0] rssi);
        logic [2:0] raw;
        zone_word_t want;
        want.lost = 1'b0;
        if (req == REQ_SAMPLE)
        begin
            ring_sum     = ring_sum - ring[wr_ptr] + int'(rssi);
            ring[wr_ptr] = rssi;
            wr_ptr       = (wr_ptr + 1) % RING_DEPTH;
            avg_lvl      = ring_sum / RING_DEPTH;
            quiet_ms     = 0;
            linked       = 1'b1;
            if (seeds < RING_DEPTH)
                seeds++;
            if (avg_lvl >= entry_lvl[5])
                raw = ZONE_5;
            else if (avg_lvl >= entry_lvl[4])
                raw = ZONE_4;
            else if (avg_lvl >= entry_lvl[3])
                raw = ZONE_3;
            else if (avg_lvl >= entry_lvl[2])
                raw = ZONE_2;
            else
                raw = ZONE_1;
            // upgrade at once, downgrade only past the hysteresis band
            if (raw > cur_zone)
                cur_zone = raw;
            else if (raw < cur_zone && avg_lvl < entry_lvl[cur_zone] - hyst)
                cur_zone = raw;
        end
        else
        begin
            if (quiet_ms < QUIET_MAX)
                quiet_ms++;
            if (linked && quiet_ms > tmo)
            begin
                linked    = 1'b0;
                cur_zone  = ZONE_1;
                refill_ring();
                avg_lvl   = far_lvl;
                want.lost = 1'b1;
            end
        end
        want.smoothed = avg_lvl[7:0];
        want.zone     = cur_zone;
        if (avg_lvl <= far_lvl)
            want.brightness = BRT_MIN;
        else if (avg_lvl >= near_lvl)
            want.brightness = BRT_MAX;
        else
            want.brightness = 8'((avg_lvl - far_lvl) * int'(BRT_MAX) / (near_lvl - far_lvl));
        want.present   = linked;
        want.searching = (seeds < RING_DEPTH);
        expected_q.push_back(want);
    endfunction

    function void check_field(string field_name, int want_v, int got_v);
        if (want_v != got_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d",
                     $time, field_name, want_v, got_v);
        end
    endfunction

    function void check_word(zone_word_t got);
        zone_word_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0t: result word with none expected, expected none actual %0d/%0d",
                     $time, got.smoothed, got.zone);
            return;
        end
        want = expected_q.pop_front();
        check_field("smoothed_dbm", want.smoothed, got.smoothed);
        check_field("zone", want.zone, got.zone);
        check_field("brightness", want.brightness, got.brightness);
        check_field("signal_present", want.present, got.present);
        check_field("signal_lost_event", want.lost, got.lost);
        check_field("searching", want.searching, got.searching);
    endfunction
endclass

module testbench;
    localparam int STALL_MAX      = 18;
    localparam int SETTLE_CYCLES  = 50;
    localparam int WATCHDOG_LIMIT = 1000;

    logic clk;
    logic rst_n;

    rpz_item_if   item ();
    rpz_result_if result ();
    rpz_cfg_if    cfg ();

    zone_scoreboard board;
    bit             send_calm;
    int             words_sent;
    int             stuck_cycles;

    rssi_proximity_zone_classifier_top #(
        .DEPTH (RING_DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        stuck_cycles = 0;
    end

    always @(posedge clk)
    begin
        if ((item.valid && item.ready) || (result.valid && result.ready) ||
            (cfg.valid && cfg.ready))
        begin
            stuck_cycles <= 0;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : result_sink
        int         gap;
        int         streak;
        bit         calm;
        zone_word_t got;
        streak = 0;
        calm   = 1'b0;
        result.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (streak == 0)
            begin
                calm   = ($urandom_range(0, 3) == 0);
                streak = $urandom_range(10, 60);
            end
            streak--;
            gap = calm ? 0 : $urandom_range(0, STALL_MAX);
            if (gap > 0)
            begin
                result.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result.ready <= 1'b1;
            do @(posedge clk); while (!result.valid);
            got.smoothed   = result.smoothed_dbm;
            got.zone       = result.zone;
            got.brightness = result.brightness;
            got.present    = result.signal_present;
            got.lost       = result.signal_lost_event;
            got.searching  = result.searching;
            board.check_word(got);
        end
    end

    task automatic send_word(input logic req, input logic signed [7:0] rssi);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid    <= 1'b1;
        item.req_type <= req;
        item.rssi_dbm <= rssi;
        do @(posedge clk); while (!item.ready);
        board.note_word(req, rssi);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        board.set_reg(idx, data);
    endtask

    task automatic load_setting(input int far_v, input int near_v, input int z2_v,
                                input int z3_v, input int z4_v, input int z5_v,
                                input int hyst_v, input int tmo_v);
        write_reg(REG_FAR_LEVEL, 16'(far_v));
        write_reg(REG_NEAR_LEVEL, 16'(near_v));
        write_reg(REG_ZONE2_ENTRY, 16'(z2_v));
        write_reg(REG_ZONE3_ENTRY, 16'(z3_v));
        write_reg(REG_ZONE4_ENTRY, 16'(z4_v));
        write_reg(REG_ZONE5_ENTRY, 16'(z5_v));
        write_reg(REG_HYSTERESIS, 16'(hyst_v));
        write_reg(REG_TIMEOUT_MS, 16'(tmo_v));
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_results();
        item.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic settle_all();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_random(input int budget);
        int start_cnt;
        int len;
        int v;
        int anchor;
        int anchors [6];
        start_cnt = words_sent;
        while (words_sent - start_cnt < budget)
        begin
            if ($urandom_range(0, 7) == 0)
                send_calm = !send_calm;
            anchors = '{board.far_lvl, board.near_lvl, board.entry_lvl[2],
                        board.entry_lvl[3], board.entry_lvl[4], board.entry_lvl[5]};
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    // burst of samples hovering around a threshold
                    anchor = anchors[$urandom_range(0, 5)];
                    anchor = anchor + 3 - int'($urandom_range(0, board.hyst + 6));
                    len    = $urandom_range(1, 12);
                    repeat (len)
                    begin
                        v = anchor + int'($urandom_range(0, 8)) - 4;
                        if (v > 127)
                            v = 127;
                        if (v < -128)
                            v = -128;
                        send_word(REQ_SAMPLE, 8'(v));
                    end
                end
                5, 6, 7:
                begin
                    // tick run long enough to reach the timeout when it is short
                    if (board.tmo <= 40)
                        len = board.tmo + 1 + int'($urandom_range(0, 1));
                    else
                        len = $urandom_range(1, 8);
                    repeat (len) send_word(REQ_TICK, 8'($urandom));
                end
                8:       send_word(REQ_SAMPLE, 8'($urandom));
                default: send_word(REQ_TICK, 8'($urandom));
            endcase
        end
    endtask

    initial
    begin : main_flow
        int far_v;
        int near_v;
        int hyst_v;
        int tmo_v;
        int zq [$];
        int extreme_lvls [8];
        extreme_lvls  = '{-128, 0, 127, -1, -50, -60, -70, -80};
        item.valid    <= 1'b0;
        item.req_type <= REQ_SAMPLE;
        item.rssi_dbm <= '0;
        cfg.valid     <= 1'b0;
        cfg.index     <= REG_FAR_LEVEL;
        cfg.data      <= '0;
        rst_n         <= 1'b0;
        send_calm     = 1'b0;
        words_sent    = 0;
        board         = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // ticks with link down, extreme samples, then up and down moves
        send_word(REQ_TICK, 8'sd0);
        send_word(REQ_TICK, -8'sd1);
        foreach (extreme_lvls[i])
            send_word(REQ_SAMPLE, 8'(extreme_lvls[i]));
        send_word(REQ_TICK, 8'sd85);
        repeat (4) send_word(REQ_SAMPLE, -8'sd85);
        repeat (4) send_word(REQ_SAMPLE, -8'sd45);
        settle_all();

        // near below far, zero timeout
        load_setting(-50, -90, -80, -70, -60, -50, 0, 0);
        send_word(REQ_TICK, 8'sd0);
        send_word(REQ_SAMPLE, -8'sd60);
        send_word(REQ_SAMPLE, -8'sd40);
        send_word(REQ_TICK, -8'sd128);
        send_word(REQ_TICK, 8'sd127);
        settle_all();

        load_setting(-90, -50, -80, -70, -60, -50, 3, 6);
        run_random(60);
        wait_results();
        run_random(60);
        settle_all();

        load_setting(-128, 0, -100, -75, -50, -25, 63, 65535);
        run_random(120);
        settle_all();

        load_setting(-1, -128, -128, -127, -2, -1, 0, 1);
        run_random(120);
        settle_all();

        load_setting(0, 127, -10, 10, 40, 127, 17, 12);
        run_random(120);

        repeat (2)
        begin
            settle_all();
            zq.delete();
            repeat (4) zq.push_back(int'($urandom_range(0, 255)) - 128);
            zq.sort();
            far_v  = int'($urandom_range(0, 140)) - 128;
            near_v = far_v + int'($urandom_range(5, 100));
            if (near_v > 127)
                near_v = 127;
            hyst_v = $urandom_range(0, 63);
            if ($urandom_range(0, 3) == 0)
                tmo_v = $urandom_range(100, 3000);
            else
                tmo_v = $urandom_range(0, 30);
            load_setting(far_v, near_v, zq[0], zq[1], zq[2], zq[3], hyst_v, tmo_v);
            run_random(110);
        end
        settle_all();

        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

/* files.f */
rtl/rpz_pkg.sv
rtl/rpz_if.sv
rtl/rpz_ram.sv
rtl/rpz_div.sv
rtl/rpz_datapath.sv
rtl/rpz_ctrl.sv
rtl/rssi_proximity_zone_classifier_top.sv
sim/testbench.sv
